// File: sv/tpbt_pkg.sv
package tpbt_pkg;

  localparam int DefNumEntries = 32;
  localparam int DefNumWarps   = 64;
  localparam int CntW          = 20;
  localparam int MaskW         = 64;

  typedef enum logic [2:0] {
    CMD_INIT         = 3'd0,
    CMD_INVAL        = 3'd1,
    CMD_ARRIVE       = 3'd2,
    CMD_EXPECT_TX    = 3'd3,
    CMD_ARRIVE_EXP   = 3'd4,
    CMD_COMPLETE_TX  = 3'd5,
    CMD_TRY_WAIT     = 3'd6,
    CMD_CLEANUP      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_COLLISION = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] cta_key;
    logic [4:0]  hw_cta;
    logic [31:0] barrier_addr;
    logic [19:0] count;
    logic        parity;
    logic [5:0]  warp;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] released_mask;
    logic        wait_done;
    logic        phase_advanced;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_OUT
  } fsm_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic search;
    logic update;
  } ctl_t;

endpackage

// File: sv/tpbt_ctrl.sv
module tpbt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output tpbt_pkg::ctl_t    ctl
);
  import tpbt_pkg::*;

  fsm_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_SEARCH;
      S_SEARCH: state_next = S_UPDATE;
      S_UPDATE: state_next = S_OUT;
      S_OUT: begin
        if (!out_stall) state_next = in_valid ? S_SEARCH : S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        ctl.load = in_valid;
      end
      S_SEARCH: ctl.search = 1'b1;
      S_UPDATE: ctl.update = 1'b1;
      S_OUT: begin
        out_valid = 1'b1;
        in_stall  = out_stall;
        ctl.load  = in_valid && !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// File: sv/tpbt_dp.sv
module tpbt_dp #(
  parameter int NumEntries = tpbt_pkg::DefNumEntries,
  parameter int NumWarps   = tpbt_pkg::DefNumWarps
) (
  input  logic           clk,
  input  logic           rst,
  input  tpbt_pkg::ctl_t ctl,
  input  tpbt_pkg::req_t req_in,
  output tpbt_pkg::rsp_t rsp
);
  import tpbt_pkg::*;

  localparam int IdxW = (NumEntries > 1) ? $clog2(NumEntries) : 1;
  localparam logic [CntW-1:0] CntMax = '1;

  // key, address and hw_cta in flops; key and address feed the associative search
  logic [NumEntries-1:0] valid;
  logic [15:0]           ecta  [NumEntries];
  logic [4:0]            ehw   [NumEntries];
  logic [31:0]           eaddr [NumEntries];
  // per-entry payload, one read and one write address
  logic [CntW-1:0]       mexp  [NumEntries];
  logic [CntW-1:0]       mpend [NumEntries];
  logic [CntW-1:0]       mtx   [NumEntries];
  logic                  mph   [NumEntries];
  logic [MaskW-1:0]      mwait [NumEntries];

  req_t                  req;
  logic                  hit, has_free;
  logic [IdxW-1:0]       hit_idx, free_idx;
  logic [CntW-1:0]       r_exp, r_pend, r_tx;
  logic                  r_ph;
  logic [MaskW-1:0]      r_wait;

  logic                  hit_c, free_c;
  logic [IdxW-1:0]       hit_idx_c, free_idx_c;

  always_comb begin
    hit_c = 1'b0; hit_idx_c = '0; free_c = 1'b0; free_idx_c = '0;
    for (int i = NumEntries - 1; i >= 0; i--) begin
      if (valid[i] && ecta[i] == req.cta_key && eaddr[i] == req.barrier_addr) begin
        hit_c = 1'b1; hit_idx_c = IdxW'(i);
      end
      if (!valid[i]) begin
        free_c = 1'b1; free_idx_c = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) req <= req_in;
    if (ctl.search) begin
      hit <= hit_c; hit_idx <= hit_idx_c;
      has_free <= free_c; free_idx <= free_idx_c;
      r_exp  <= mexp[hit_idx_c];
      r_pend <= mpend[hit_idx_c];
      r_tx   <= mtx[hit_idx_c];
      r_ph   <= mph[hit_idx_c];
      r_wait <= mwait[hit_idx_c];
    end
  end

  // update arithmetic
  logic [CntW:0]    tx_sum;
  logic [CntW-1:0]  tx_exp, pend_n, tx_n, pend_fin;
  logic [MaskW-1:0] wait_n, warp_bit;
  logic             ph_n, adv, chk;
  rsp_t             rsp_n;
  cmd_t             cmd;

  assign cmd = cmd_t'(req.command);

  always_comb begin
    tx_sum = {1'b0, r_tx} + {1'b0, req.count};
    tx_exp = tx_sum[CntW] ? CntMax : tx_sum[CntW-1:0];
    warp_bit = '0;
    if (32'(req.warp) < NumWarps) warp_bit[req.warp] = 1'b1;
    pend_n = r_pend; tx_n = r_tx; wait_n = r_wait; chk = 1'b0;
    rsp_n = '0;
    unique case (cmd)
      CMD_ARRIVE: begin
        pend_n = (req.count >= r_pend) ? '0 : r_pend - req.count; chk = 1'b1;
      end
      CMD_EXPECT_TX: tx_n = tx_exp;
      CMD_ARRIVE_EXP: begin
        tx_n = tx_exp; pend_n = (r_pend == '0) ? '0 : r_pend - 1'b1; chk = 1'b1;
      end
      CMD_COMPLETE_TX: begin
        tx_n = (req.count >= r_tx) ? '0 : r_tx - req.count; chk = 1'b1;
      end
      CMD_TRY_WAIT: begin
        if (req.parity != r_ph) rsp_n.wait_done = 1'b1;
        else                    wait_n = r_wait | warp_bit;
      end
      default: ;
    endcase
    adv = chk && pend_n == '0 && tx_n == '0;
    pend_fin = adv ? r_exp : pend_n;
    ph_n = r_ph ^ adv;
    if (adv) begin
      rsp_n.released_mask = r_wait; rsp_n.phase_advanced = 1'b1; wait_n = '0;
    end
    if (cmd == CMD_INIT) begin
      rsp_n = '0;
      if (hit) rsp_n.status = (r_exp != req.count) ? ST_COLLISION : ST_OK;
      else if (!has_free) rsp_n.status = ST_FULL;
    end else if (cmd != CMD_CLEANUP && !hit) begin
      rsp_n = '0; rsp_n.status = ST_NOT_FOUND;
    end else if (cmd == CMD_CLEANUP) begin
      rsp_n = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.update) begin
      rsp <= rsp_n;
      if (cmd == CMD_INIT && !hit && has_free) begin
        ecta[free_idx] <= req.cta_key; ehw[free_idx] <= req.hw_cta;
        eaddr[free_idx] <= req.barrier_addr; mexp[free_idx] <= req.count;
        mpend[free_idx] <= req.count; mtx[free_idx] <= '0;
        mph[free_idx] <= 1'b0; mwait[free_idx] <= '0;
      end else if (hit && cmd != CMD_INIT && cmd != CMD_CLEANUP && cmd != CMD_INVAL) begin
        mpend[hit_idx] <= pend_fin; mtx[hit_idx] <= tx_n;
        mph[hit_idx] <= ph_n; mwait[hit_idx] <= wait_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= '0;
    else if (ctl.update) begin
      if (cmd == CMD_INIT && !hit && has_free) valid[free_idx] <= 1'b1;
      else if (cmd == CMD_INVAL && hit) valid[hit_idx] <= 1'b0;
      else if (cmd == CMD_CLEANUP) begin
        for (int i = 0; i < NumEntries; i++)
          if (ehw[i] == req.hw_cta) valid[i] <= 1'b0;
      end
    end
  end

endmodule

// File: sv/transaction_phase_barrier_table.sv
// Transaction phase barrier table.
// Requests enter on the in channel (in_valid / in_stall, payload in_req) and
// each request yields exactly one response on the out channel (out_valid /
// out_stall, payload out_rsp). A request is taken when valid is high and
// stall is low on the same rising edge.
// A taken request passes through the search and update states, and its response
// is presented in the out state. Requests are handled one at a time: search the
// key table, read-modify-write the matched entry, then present the response. The
// next request is accepted in the same cycle the response is taken.
// Reset (rst, synchronous, active high) invalidates every entry and returns
// the controller to idle; entry contents are written by init before use.
// When the receiver stalls, hold the response and stall the input side.
// Cleanup clears all entries of one hardware CTA in a single update.
module transaction_phase_barrier_table #(
  parameter int NumEntries = tpbt_pkg::DefNumEntries,
  parameter int NumWarps   = tpbt_pkg::DefNumWarps
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  tpbt_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output tpbt_pkg::rsp_t out_rsp
);
  import tpbt_pkg::*;

  ctl_t ctl;

  // sequence search, update and response
  tpbt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .ctl
  );

  // hold table state and compute the response
  tpbt_dp #(.NumEntries(NumEntries), .NumWarps(NumWarps)) u_dp (
    .clk, .rst, .ctl, .req_in(in_req), .rsp(out_rsp)
  );

endmodule
